// ===== src/ifmt_pkg.sv =====
// ============================================================================
// ifmt_pkg
// Shared types, constants and the digit-character function of the integer field formatter.
// ============================================================================
package ifmt_pkg;

    localparam int DIGIT_SLOTS = 16;
    localparam int MAX_FIELD   = 64;

    localparam int DIW = $clog2(DIGIT_SLOTS);       // digit store index
    localparam int DCW = $clog2(DIGIT_SLOTS + 1);   // digit count
    localparam int FCW = $clog2(MAX_FIELD + 1);     // field counts
    localparam int PREC_MAX = MAX_FIELD - 2;

    localparam int CONV_W  = 3;
    localparam int VALUE_W = 32;
    localparam int FW_W    = 7;
    localparam int PREC_W  = 7;
    localparam int CH_W    = 8;

    // reciprocal of ten, exact for 32-bit dividends with a shift of 35
    localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP_SH = 35;

    localparam logic [CH_W-1:0] ASC_BLANK = 8'h20;
    localparam logic [CH_W-1:0] ASC_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] ASC_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] ASC_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] ASC_LX    = 8'h78;
    localparam logic [CH_W-1:0] ASC_UX    = 8'h58;
    localparam logic [CH_W-1:0] ASC_NUL   = 8'h00;

    typedef enum logic [CONV_W-1:0] {
        CONV_SDEC = 3'd0,
        CONV_UDEC = 3'd1,
        CONV_OCT  = 3'd2,
        CONV_LHEX = 3'd3,
        CONV_UHEX = 3'd4,
        CONV_CHAR = 3'd5
    } t_conv;

    typedef enum logic [2:0] {
        PFX_NONE  = 3'd0,
        PFX_MINUS = 3'd1,
        PFX_PLUS  = 3'd2,
        PFX_BLANK = 3'd3,
        PFX_LHEX  = 3'd4,
        PFX_UHEX  = 3'd5
    } t_prefix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_SHIFT,
        S_ZCNT,
        S_SIZE,
        S_EMIT,
        S_NULL
    } t_state;

    // digit value to ASCII: 0-9, then a-f or A-F
    function automatic logic [CH_W-1:0] ifmt_digit_char(input logic [3:0] d,
                                                        input logic upper);
        logic [CH_W-1:0] c;
        if (d < 4'd10) begin
            c = ASC_ZERO + {4'd0, d};
        end else if (upper) begin
            c = 8'h41 + {4'd0, d - 4'd10};
        end else begin
            c = 8'h61 + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== src/ifmt_req_if.sv =====
// ============================================================================
// ifmt_req_if
// Request channel: one parsed conversion with value, flags, width, precision.
// ============================================================================
interface ifmt_req_if;
    import ifmt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CONV_W-1:0]        conv;
    logic [VALUE_W-1:0]       value;
    logic                     plus_flag;
    logic                     left_flag;
    logic                     blank_flag;
    logic                     alt_flag;
    logic                     zero_flag;
    logic [FW_W-1:0]          field_width;
    logic signed [PREC_W-1:0] precision;

    modport source (
        output valid, conv, value, plus_flag, left_flag, blank_flag, alt_flag,
               zero_flag, field_width, precision,
        input  ready
    );
    modport sink (
        input  valid, conv, value, plus_flag, left_flag, blank_flag, alt_flag,
               zero_flag, field_width, precision,
        output ready
    );
endinterface

// ===== src/ifmt_rsp_if.sv =====
// ============================================================================
// ifmt_rsp_if
// Response channel: one field character per transfer (none for an empty field), last marks the end.
// ============================================================================
interface ifmt_rsp_if;
    import ifmt_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            has_char;
    logic            last;

    modport source (output valid, ch, has_char, last, input ready);
    modport sink   (input valid, ch, has_char, last, output ready);
endinterface

// ===== src/integer_field_formatter.sv =====
// Sequence: request transfer, then for each decimal digit a multiply by the
// reciprocal of ten and a fix-up, or a shift for each octal/hex digit, then
// the zero-count and sizing states, then one character per cycle while the
// output side takes them.
// Not ready in flight. Sync reset: sequencer idle, output register empty.
// ============================================================================
// integer_field_formatter
// printf-style integer/char field formatter driven by one shared digit unit.
// ============================================================================
module integer_field_formatter (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ifmt_req_if.sink   i_req,
    ifmt_rsp_if.source o_rsp
);
    import ifmt_pkg::*;

    localparam int SW = FCW + 1;
    localparam int PROD_W = 2 * VALUE_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    t_conv               r_conv, n_conv;
    t_prefix             r_pfx, n_pfx;
    logic                r_left, n_left;
    logic                r_alt, n_alt;
    logic [VALUE_W-1:0]  r_work, n_work;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [CH_W-1:0]     r_char, n_char;
    logic [DCW-1:0]      r_dig_cnt, n_dig_cnt;
    logic [1:0]          r_pre_cnt, n_pre_cnt;
    logic [FCW-1:0]      r_prec, n_prec;
    logic [FCW-1:0]      r_width, n_width;
    logic [FCW-1:0]      r_zero_cnt, n_zero_cnt;
    logic [FCW-1:0]      r_blank_cnt, n_blank_cnt;
    logic [FCW-1:0]      r_remain, n_remain;
    logic [3:0]          r_digit [DIGIT_SLOTS];

    // output register
    logic                r_out_valid, n_out_valid;
    logic [CH_W-1:0]     r_out_ch, n_out_ch;
    logic                r_out_has, n_out_has;
    logic                r_out_last, n_out_last;

    // ------------------------------------------------------------------
    // Request decode (combinational, only used on a request transfer)
    // ------------------------------------------------------------------
    logic                req_xfer;
    t_conv               a_conv;
    logic                a_neg;
    logic [VALUE_W-1:0]  a_mag;
    t_prefix             a_pfx;
    logic [1:0]          a_plen;
    logic [FCW-1:0]      a_width;
    logic [FCW-1:0]      a_prec;
    logic [FCW-1:0]      a_room;

    assign req_xfer = i_req.valid && i_req.ready;

    always_comb begin
        case (i_req.conv)
            CONV_SDEC: a_conv = CONV_SDEC;
            CONV_OCT:  a_conv = CONV_OCT;
            CONV_LHEX: a_conv = CONV_LHEX;
            CONV_UHEX: a_conv = CONV_UHEX;
            CONV_CHAR: a_conv = CONV_CHAR;
            default:   a_conv = CONV_UDEC;   // unsigned decimal and unused codes
        endcase
    end

    always_comb begin
        a_neg = (a_conv == CONV_SDEC) && i_req.value[VALUE_W-1];
        a_mag = a_neg ? (VALUE_W'(0) - i_req.value) : i_req.value;

        // sign or hex prefix
        a_pfx = PFX_NONE;
        if (a_conv == CONV_SDEC) begin
            if (a_neg)                 a_pfx = PFX_MINUS;
            else if (i_req.plus_flag)  a_pfx = PFX_PLUS;
            else if (i_req.blank_flag) a_pfx = PFX_BLANK;
        end
        if (i_req.alt_flag && (i_req.value != '0)) begin
            if (a_conv == CONV_LHEX) a_pfx = PFX_LHEX;
            if (a_conv == CONV_UHEX) a_pfx = PFX_UHEX;
        end
        case (a_pfx) inside
            PFX_NONE:             a_plen = 2'd0;
            PFX_LHEX, PFX_UHEX:   a_plen = 2'd2;
            default:              a_plen = 2'd1;
        endcase

        // saturate width and precision
        if (i_req.field_width > FW_W'(MAX_FIELD)) a_width = FCW'(MAX_FIELD);
        else                                      a_width = FCW'(i_req.field_width);
        if (i_req.precision[PREC_W-1])                   a_prec = FCW'(1);
        else if (i_req.precision > PREC_W'(PREC_MAX))    a_prec = FCW'(PREC_MAX);
        else                                             a_prec = FCW'(i_req.precision);

        // zero flag: digits fill what the prefix leaves of the width
        a_room = a_width - FCW'(a_plen);
        if (i_req.zero_flag && (a_width > FCW'(a_plen)) && (a_room > a_prec)) begin
            a_prec = a_room;
        end
    end

    // ------------------------------------------------------------------
    // Shared digit unit
    // ------------------------------------------------------------------
    logic [PROD_W-RECIP_SH-1:0] q10;      // quotient by ten
    logic [3:0]                 q10_lo;   // low bits of q10 * 10
    logic [3:0]                 rem10;
    logic [3:0]                 sh_digit;
    logic [VALUE_W-1:0]         sh_work;
    logic [DIW-1:0]             wr_idx;
    logic                       dig_full;

    assign q10      = r_prod[PROD_W-1:RECIP_SH];
    assign q10_lo   = {q10[0], 3'b000} + {q10[2:0], 1'b0};
    assign rem10    = r_work[3:0] - q10_lo;
    assign sh_digit = (r_conv == CONV_OCT) ? {1'b0, r_work[2:0]} : r_work[3:0];
    assign sh_work  = (r_conv == CONV_OCT) ? (r_work >> 3) : (r_work >> 4);
    assign wr_idx   = r_dig_cnt[DIW-1:0];
    assign dig_full = (r_dig_cnt + DCW'(1)) == DCW'(DIGIT_SLOTS);

    // ------------------------------------------------------------------
    // Sizing
    // ------------------------------------------------------------------
    logic [SW-1:0]  used;
    logic [FCW-1:0] z_cnt;

    always_comb begin
        if (r_conv == CONV_CHAR) begin
            z_cnt = '0;
        end else begin
            z_cnt = (r_prec > FCW'(r_dig_cnt)) ? (r_prec - FCW'(r_dig_cnt)) : '0;
            // '#' octal: at least one leading zero ahead of nonzero digits
            if ((r_conv == CONV_OCT) && r_alt && (r_dig_cnt != '0) && (z_cnt == '0)) begin
                z_cnt = FCW'(1);
            end
        end
    end

    assign used = SW'(r_pre_cnt) + SW'(r_zero_cnt) + SW'(r_dig_cnt);

    // ------------------------------------------------------------------
    // Character selection, in field order
    // ------------------------------------------------------------------
    logic            out_room;
    logic            emit_go;
    logic [CH_W-1:0] em_ch;
    logic [DIW-1:0]  rd_idx;
    logic            sel_lblank, sel_pre, sel_zero, sel_dig;
    logic [CH_W-1:0] pre_ch;

    assign out_room = !r_out_valid || o_rsp.ready;
    assign emit_go  = (r_state == S_EMIT) && out_room;
    assign rd_idx   = DIW'(r_dig_cnt - DCW'(1));

    assign sel_lblank = !r_left && (r_blank_cnt != '0);
    assign sel_pre    = !sel_lblank && (r_pre_cnt != '0);
    assign sel_zero   = !sel_lblank && !sel_pre && (r_zero_cnt != '0);
    assign sel_dig    = !sel_lblank && !sel_pre && !sel_zero && (r_dig_cnt != '0);

    always_comb begin
        unique case (r_pfx)
            PFX_MINUS: pre_ch = ASC_MINUS;
            PFX_PLUS:  pre_ch = ASC_PLUS;
            PFX_BLANK: pre_ch = ASC_BLANK;
            PFX_LHEX:  pre_ch = (r_pre_cnt == 2'd2) ? ASC_ZERO : ASC_LX;
            PFX_UHEX:  pre_ch = (r_pre_cnt == 2'd2) ? ASC_ZERO : ASC_UX;
            default:   pre_ch = ASC_NUL;
        endcase
    end

    always_comb begin
        if (sel_lblank)    em_ch = ASC_BLANK;
        else if (sel_pre)  em_ch = pre_ch;
        else if (sel_zero) em_ch = ASC_ZERO;
        else if (sel_dig)  em_ch = (r_conv == CONV_CHAR) ? r_char
                                 : ifmt_digit_char(r_digit[rd_idx], r_conv == CONV_UHEX);
        else               em_ch = ASC_BLANK;   // right padding
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    if (a_conv == CONV_CHAR || a_mag == '0)       n_state = S_ZCNT;
                    else if (a_conv == CONV_SDEC || a_conv == CONV_UDEC) n_state = S_MUL;
                    else                                          n_state = S_SHIFT;
                end
            end
            S_MUL:   n_state = S_FIX;
            S_FIX:   n_state = (q10 == '0 || dig_full) ? S_ZCNT : S_MUL;
            S_SHIFT: n_state = (sh_work == '0 || dig_full) ? S_ZCNT : S_SHIFT;
            S_ZCNT:  n_state = S_SIZE;
            S_SIZE:  n_state = ((r_width == '0) && (used == '0)) ? S_NULL : S_EMIT;
            S_EMIT:  if (emit_go && (r_remain == FCW'(1))) n_state = S_IDLE;
            S_NULL:  if (out_room) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and output register updates
    // ------------------------------------------------------------------
    always_comb begin
        n_conv      = r_conv;
        n_pfx       = r_pfx;
        n_left      = r_left;
        n_alt       = r_alt;
        n_work      = r_work;
        n_prod      = r_prod;
        n_char      = r_char;
        n_dig_cnt   = r_dig_cnt;
        n_pre_cnt   = r_pre_cnt;
        n_prec      = r_prec;
        n_width     = r_width;
        n_zero_cnt  = r_zero_cnt;
        n_blank_cnt = r_blank_cnt;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_ch    = r_out_ch;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_conv    = a_conv;
                    n_left    = i_req.left_flag;
                    n_alt     = i_req.alt_flag;
                    n_work    = a_mag;
                    n_char    = i_req.value[CH_W-1:0];
                    n_width   = a_width;
                    n_prec    = a_prec;
                    if (a_conv == CONV_CHAR) begin
                        n_pfx     = PFX_NONE;
                        n_pre_cnt = 2'd0;
                        n_dig_cnt = DCW'(1);
                    end else begin
                        n_pfx     = a_pfx;
                        n_pre_cnt = a_plen;
                        n_dig_cnt = '0;
                    end
                end
            end
            S_MUL: begin
                n_prod = {{VALUE_W{1'b0}}, r_work} * {{VALUE_W{1'b0}}, RECIP10};
            end
            S_FIX: begin
                n_work    = VALUE_W'(q10);
                n_dig_cnt = r_dig_cnt + DCW'(1);
            end
            S_SHIFT: begin
                n_work    = sh_work;
                n_dig_cnt = r_dig_cnt + DCW'(1);
            end
            S_ZCNT: begin
                n_zero_cnt = z_cnt;
            end
            S_SIZE: begin
                if (SW'(r_width) > used) begin
                    n_blank_cnt = r_width - FCW'(used);
                    n_remain    = r_width;
                end else begin
                    n_blank_cnt = '0;
                    n_remain    = FCW'(used);
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = em_ch;
                    n_out_has   = 1'b1;
                    n_out_last  = (r_remain == FCW'(1));
                    n_remain    = r_remain - FCW'(1);
                    if (sel_pre)       n_pre_cnt   = r_pre_cnt - 2'd1;
                    else if (sel_zero) n_zero_cnt  = r_zero_cnt - FCW'(1);
                    else if (sel_dig)  n_dig_cnt   = r_dig_cnt - DCW'(1);
                    else               n_blank_cnt = r_blank_cnt - FCW'(1);
                end
            end
            S_NULL: begin
                // empty field: one transfer without a character
                if (out_room) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = ASC_NUL;
                    n_out_has   = 1'b0;
                    n_out_last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_remain    <= '0;
            r_dig_cnt   <= '0;
            r_pre_cnt   <= '0;
            r_zero_cnt  <= '0;
            r_blank_cnt <= '0;
            r_pfx       <= PFX_NONE;
            r_work      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_remain    <= n_remain;
            r_dig_cnt   <= n_dig_cnt;
            r_pre_cnt   <= n_pre_cnt;
            r_zero_cnt  <= n_zero_cnt;
            r_blank_cnt <= n_blank_cnt;
            r_pfx       <= n_pfx;
            r_work      <= n_work;
        end
    end

    always_ff @(posedge i_clk) begin
        r_conv     <= n_conv;
        r_left     <= n_left;
        r_alt      <= n_alt;
        r_prod     <= n_prod;
        r_char     <= n_char;
        r_prec     <= n_prec;
        r_width    <= n_width;
        r_out_ch   <= n_out_ch;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

    // digit store: written by the digit unit, low digit first
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIX) begin
            r_digit[wr_idx] <= rem10;
        end else if (r_state == S_SHIFT) begin
            r_digit[wr_idx] <= sh_digit;
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.ch       = r_out_ch;
    assign o_rsp.has_char = r_out_has;
    assign o_rsp.last     = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // while emitting, the remaining count matches the segments still to be sent
    a_remain_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |->
        (SW'(r_remain) == SW'(r_blank_cnt) + SW'(r_pre_cnt) + SW'(r_zero_cnt)
                          + SW'(r_dig_cnt)))
        else $error("remaining count out of step with segment counters");

    a_remain_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_remain != '0))
        else $error("emitting with nothing left");

    a_dig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dig_cnt <= DCW'(DIGIT_SLOTS))
        else $error("digit count beyond store depth");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> r_out_last)
        else $error("empty item not marked last");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && (r_remain == FCW'(1))) |=> (r_state == S_IDLE) && r_out_last)
        else $error("final character did not end the conversion");

endmodule
